/* rtl/aewd_pkg.sv */
// ----------------------------------------------------------------------------
// aewd_pkg
// Shared types and tag codes for the address-event word decoder.
// ----------------------------------------------------------------------------
package aewd_pkg;

    localparam int WORD_W    = 32;
    localparam int TAG_W     = 6;
    localparam int TAG_LSB   = 26;
    localparam int PAYLOAD_W = 24;

    // Word tags (bits 31..26)
    localparam logic [TAG_W-1:0] TAG_EVENT       = 6'd0;
    localparam logic [TAG_W-1:0] TAG_EVENT_3D    = 6'd1;
    localparam logic [TAG_W-1:0] TAG_FEAT_FIRST  = 6'd2;
    localparam logic [TAG_W-1:0] TAG_FEAT_SECOND = 6'd3;
    localparam logic [TAG_W-1:0] TAG_FEAT3D_FIRST = 6'd4;
    localparam logic [TAG_W-1:0] TAG_STAMP       = 6'd32;

    typedef enum logic [2:0] {
        KIND_STAMP      = 3'd0,
        KIND_EVENT      = 3'd1,
        KIND_EVENT_FEAT = 3'd2,
        KIND_3D         = 3'd3,
        KIND_3D_FEAT    = 3'd4,
        KIND_ERROR      = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] stamp;
        logic        polarity;
        logic [6:0]  x_addr;
        logic [7:0]  y_addr;
        logic        channel;
        logic [7:0]  disparity;
        logic [7:0]  orientation;
        logic [7:0]  flow_x;
        logic [7:0]  flow_y;
        logic        packet_done;
    } result_t;

    typedef struct packed {
        logic                 pair_pending;
        logic                 pending_is_3d;
        logic [PAYLOAD_W-1:0] pending_payload;
        logic                 skip_to_end;
    } dec_state_t;

endpackage

/* rtl/aewd_decode.sv */
// ----------------------------------------------------------------------------
// aewd_decode
// Single-word decode: result fields and next decoder state from one word.
// ----------------------------------------------------------------------------
module aewd_decode
    import aewd_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  logic              packet_end,
    input  dec_state_t        state,
    output dec_state_t        state_next,
    output logic              emit,
    output result_t           result
);

    logic [TAG_W-1:0]     tag;
    logic [PAYLOAD_W-1:0] payload;

    assign tag     = word[TAG_LSB +: TAG_W];
    assign payload = word[PAYLOAD_W-1:0];

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        result     = '0;
        result.kind = KIND_STAMP;

        if (state.skip_to_end)
        begin
            if (packet_end)
            begin
                state_next.skip_to_end = 1'b0;
            end
        end
        else if (state.pair_pending)
        begin
            emit = 1'b1;
            state_next.pair_pending = 1'b0;
            if (tag != TAG_FEAT_SECOND)
            begin
                result.kind            = KIND_ERROR;
                result.packet_done     = 1'b1;
                state_next.skip_to_end = !packet_end;
            end
            else
            begin
                result.kind        = state.pending_is_3d ? KIND_3D_FEAT : KIND_EVENT_FEAT;
                result.polarity    = state.pending_payload[0];
                result.x_addr      = state.pending_payload[7:1];
                result.y_addr      = state.pending_payload[15:8];
                if (state.pending_is_3d)
                begin
                    result.disparity = state.pending_payload[23:16];
                end
                else
                begin
                    result.channel = state.pending_payload[16];
                end
                result.orientation = payload[7:0];
                result.flow_x      = payload[15:8];
                result.flow_y      = payload[23:16];
                result.packet_done = packet_end;
            end
        end
        else
        begin
            unique case (tag)
                TAG_STAMP:
                begin
                    emit               = 1'b1;
                    result.kind        = KIND_STAMP;
                    result.stamp       = payload;
                    result.packet_done = packet_end;
                end
                TAG_EVENT:
                begin
                    emit               = 1'b1;
                    result.kind        = KIND_EVENT;
                    result.polarity    = payload[0];
                    result.x_addr      = payload[7:1];
                    result.y_addr      = payload[15:8];
                    result.channel     = payload[16];
                    result.packet_done = packet_end;
                end
                TAG_EVENT_3D:
                begin
                    emit               = 1'b1;
                    result.kind        = KIND_3D;
                    result.polarity    = payload[0];
                    result.x_addr      = payload[7:1];
                    result.y_addr      = payload[15:8];
                    result.disparity   = payload[23:16];
                    result.packet_done = packet_end;
                end
                TAG_FEAT_FIRST, TAG_FEAT3D_FIRST:
                begin
                    if (packet_end)
                    begin
                        // pair cut short by end of packet
                        emit               = 1'b1;
                        result.kind        = KIND_ERROR;
                        result.packet_done = 1'b1;
                    end
                    else
                    begin
                        state_next.pair_pending    = 1'b1;
                        state_next.pending_is_3d   = (tag == TAG_FEAT3D_FIRST);
                        state_next.pending_payload = payload;
                    end
                end
                default:
                begin
                    emit                   = 1'b1;
                    result.kind            = KIND_ERROR;
                    result.packet_done     = 1'b1;
                    state_next.skip_to_end = !packet_end;
                end
            endcase
        end
    end

endmodule

/* rtl/address_event_word_decoder_core.sv */
// ----------------------------------------------------------------------------
// address_event_word_decoder_core
// Decodes tagged 32-bit packet words into stamp, event, feature and error results.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one packet word (word, packet_end)
// per beat. Output channel: out_valid/out_ready carry one decoded result per
// beat (kind and its fields, unused fields zero).
// A word passes an input register, then one decode step into the result
// register; out_valid rises once its result is written there, and a full
// result register with out_ready low holds the word in the input register.
// One word is taken per cycle; the input register refills while a finished
// result waits, so only a stalled result with a full input register holds
// in_ready low. The first word of a feature pair gives no result; the pair
// result leaves with its second word. An error gives one result with
// packet_done set, and further words of that packet give none.
// Reset clears both valid flags and the decoder state (no pair held, not
// dropping). While out_ready is low the result holds and, once the input
// register is full, in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module address_event_word_decoder_core
    import aewd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [WORD_W-1:0] word,
    input  logic              packet_end,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        kind,
    output logic [23:0]       stamp,
    output logic              polarity,
    output logic [6:0]        x_addr,
    output logic [7:0]        y_addr,
    output logic              channel,
    output logic [7:0]        disparity,
    output logic [7:0]        orientation,
    output logic [7:0]        flow_x,
    output logic [7:0]        flow_y,
    output logic              packet_done
);

    logic              in_valid_reg;
    logic [WORD_W-1:0] word_reg;
    logic              end_reg;
    logic              out_valid_reg;
    result_t           result_reg;
    dec_state_t        state_reg;
    dec_state_t        state_next;
    result_t           result_next;
    logic              emit;
    logic              advance;

    // the input register moves on whenever the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    aewd_decode u_decode (
        .word       (word_reg),
        .packet_end (end_reg),
        .state      (state_reg),
        .state_next (state_next),
        .emit       (emit),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word;
            end_reg  <= packet_end;
        end
        if (advance && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = result_reg.kind;
    assign stamp       = result_reg.stamp;
    assign polarity    = result_reg.polarity;
    assign x_addr      = result_reg.x_addr;
    assign y_addr      = result_reg.y_addr;
    assign channel     = result_reg.channel;
    assign disparity   = result_reg.disparity;
    assign orientation = result_reg.orientation;
    assign flow_x      = result_reg.flow_x;
    assign flow_y      = result_reg.flow_y;
    assign packet_done = result_reg.packet_done;

    a_error_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.kind == KIND_ERROR) |-> result_reg.packet_done)
        else $error("error result without packet_done");

    a_state_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.skip_to_end && state_reg.pair_pending))
        else $error("dropping while a pair is held");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    a_stamp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.kind == KIND_STAMP) |->
            (result_reg.x_addr == 7'd0 && result_reg.flow_y == 8'd0))
        else $error("stamp result carries event fields");

endmodule
